### src/tlb_pkg.sv
// Shared constants, types and handshake structs for the TLB translator.
`timescale 1ns / 1ps
`default_nettype none

package tlb_pkg;

    localparam int ADDR_WIDTH   = 16;
    localparam int OFFSET_WIDTH = 8;
    localparam int PAGE_COUNT   = 256;
    localparam int PAGE_WIDTH   = $clog2(PAGE_COUNT);
    localparam int FRAME_WIDTH  = PAGE_WIDTH;
    localparam int FREE_WIDTH   = PAGE_WIDTH + 1;
    localparam int TLB_ENTRIES  = 16;
    localparam int SLOT_WIDTH   = $clog2(TLB_ENTRIES);
    localparam int COUNT_WIDTH  = 32;

    typedef logic [ADDR_WIDTH-1:0]   addr_t;
    typedef logic [OFFSET_WIDTH-1:0] offset_t;
    typedef logic [PAGE_WIDTH-1:0]   page_t;
    typedef logic [FRAME_WIDTH-1:0]  frame_t;
    typedef logic [FREE_WIDTH-1:0]   free_t;
    typedef logic [SLOT_WIDTH-1:0]   slot_t;
    typedef logic [COUNT_WIDTH-1:0]  count_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic finish_hit;
        logic finish_walk;
    } tlb_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic hit;
    } tlb_sts_t;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_LOOKUP = 3'b010,
        ST_WALK   = 3'b100
    } tlb_state_t;

endpackage

`default_nettype wire

### src/tlb_page_table_translator.sv
// Top level of the TLB translator with demand-paged page table.
//
//  channel   | handshake          | payload
//  ----------+--------------------+-----------------------------------------------
//  request   | start, busy        | virtual_address
//  result    | done (1-cycle)     | phys_addr, tlb_hit, page_fault,
//            |                    | translation_count, hit_count, fault_count
//
// A transaction is taken on a clock edge with start high and busy low.
// TLB hit: the lookup state finishes the transaction, the result is registered
// and busy drops as the result is shown.
// TLB miss: the controller adds a walk state, since the page table RAM read
// port is registered; the walk state then finishes the transaction.
// Reset clears the TLB and page table valid bits, the FIFO slot, the free
// frame counter and all counts; no clearing pass is needed.
// The result is shown for exactly one cycle with done high and cannot be held;
// the next request is accepted while a result is being shown.
`timescale 1ns / 1ps
`default_nettype none

module tlb_page_table_translator (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    output logic                busy,
    input  wire tlb_pkg::addr_t virtual_address,
    output logic                done,
    output tlb_pkg::addr_t      phys_addr,
    output logic                tlb_hit,
    output logic                page_fault,
    output tlb_pkg::count_t     translation_count,
    output tlb_pkg::count_t     hit_count,
    output tlb_pkg::count_t     fault_count
);
    import tlb_pkg::*;

    tlb_cmd_t cmd;
    tlb_sts_t sts;

    // Sequence lookup and walk
    tlb_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd),
        .sts   (sts)
    );

    // Hold the TLB, the page table, the allocator and the counts
    tlb_dp u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .sts               (sts),
        .virtual_address   (virtual_address),
        .done              (done),
        .phys_addr         (phys_addr),
        .tlb_hit           (tlb_hit),
        .page_fault        (page_fault),
        .translation_count (translation_count),
        .hit_count         (hit_count),
        .fault_count       (fault_count)
    );

    // A result only follows a cycle of work on a transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without a transaction in flight");

    // An accepted transaction keeps the block busy in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    // A TLB hit never allocates a frame
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(tlb_hit && page_fault))
        else $error("hit and fault reported together");

    // Hits and faults never outnumber translations
    assert property (@(posedge clk) disable iff (!rst_n)
        (hit_count <= translation_count) && (fault_count <= translation_count))
        else $error("hit or fault count exceeds translation count");

endmodule

`default_nettype wire

### src/tlb_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module tlb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### src/tlb_ctrl.sv
// Sequencer for lookup and page walk of one translation.
`timescale 1ns / 1ps
`default_nettype none

module tlb_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    output tlb_pkg::tlb_cmd_t      cmd,
    input  wire tlb_pkg::tlb_sts_t sts
);
    import tlb_pkg::*;

    tlb_state_t state_reg;
    tlb_state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                // table read is issued this cycle; wait for it only on a miss
                if (sts.hit)
                begin
                    cmd.finish_hit = 1'b1;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                cmd.finish_walk = 1'b1;
                state_next      = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

### src/tlb_dp.sv
// TLB entries, page table, frame allocator, counters and result registers.
`timescale 1ns / 1ps
`default_nettype none

module tlb_dp (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire tlb_pkg::tlb_cmd_t cmd,
    output tlb_pkg::tlb_sts_t      sts,
    input  wire tlb_pkg::addr_t    virtual_address,
    output logic                   done,
    output tlb_pkg::addr_t         phys_addr,
    output logic                   tlb_hit,
    output logic                   page_fault,
    output tlb_pkg::count_t        translation_count,
    output tlb_pkg::count_t        hit_count,
    output tlb_pkg::count_t        fault_count
);
    import tlb_pkg::*;

    addr_t   va_reg;
    page_t   tlb_page_reg  [TLB_ENTRIES];
    frame_t  tlb_frame_reg [TLB_ENTRIES];
    logic [TLB_ENTRIES-1:0] tlb_valid_reg, tlb_valid_next;
    slot_t   slot_reg, slot_next;
    logic [PAGE_COUNT-1:0]  table_valid_reg, table_valid_next;
    free_t   free_reg, free_next;
    count_t  total_reg, total_next;
    count_t  hits_reg, hits_next;
    count_t  faults_reg, faults_next;
    logic    done_reg, done_next;
    addr_t   phys_reg;
    logic    hit_reg;
    logic    fault_reg;

    page_t   page;
    offset_t offset;
    logic    lookup_hit;
    frame_t  lookup_frame;
    logic    table_hit;
    frame_t  table_rdata;
    frame_t  walk_frame;
    logic    fault;
    slot_t   slot_adv;
    logic    finish;

    assign page   = PAGE_WIDTH'(va_reg >> OFFSET_WIDTH);
    assign offset = va_reg[OFFSET_WIDTH-1:0];

    // parallel compare; lowest matching entry wins
    always_comb
    begin
        lookup_hit   = 1'b0;
        lookup_frame = '0;
        for (int i = TLB_ENTRIES - 1; i >= 0; i--)
        begin
            if (tlb_valid_reg[i] && (tlb_page_reg[i] == page))
            begin
                lookup_hit   = 1'b1;
                lookup_frame = tlb_frame_reg[i];
            end
        end
    end

    assign sts.hit = lookup_hit;

    tlb_ram #(
        .WIDTH (FRAME_WIDTH),
        .DEPTH (PAGE_COUNT)
    ) u_table (
        .clk   (clk),
        .we    (fault),
        .waddr (page),
        .wdata (walk_frame),
        .raddr (page),
        .rdata (table_rdata)
    );

    assign table_hit  = table_valid_reg[page];
    assign walk_frame = table_hit ? table_rdata : free_reg[FRAME_WIDTH-1:0];
    assign fault      = cmd.finish_walk && !table_hit;
    assign slot_adv   = slot_reg + 1'b1;
    assign finish     = cmd.finish_hit || cmd.finish_walk;

    always_comb
    begin
        tlb_valid_next   = tlb_valid_reg;
        slot_next        = slot_reg;
        table_valid_next = table_valid_reg;
        free_next        = free_reg;
        total_next       = total_reg;
        hits_next        = hits_reg;
        faults_next      = faults_reg;
        done_next        = finish;
        if (cmd.finish_walk)
        begin
            // advance the FIFO slot, then refill at the new slot
            slot_next                = slot_adv;
            tlb_valid_next[slot_adv] = 1'b1;
        end
        if (fault)
        begin
            table_valid_next[page] = 1'b1;
            if (free_reg < FREE_WIDTH'(PAGE_COUNT))
            begin
                free_next = free_reg + 1'b1;
            end
        end
        if (finish && (total_reg != '1))
        begin
            total_next = total_reg + 1'b1;
        end
        if (cmd.finish_hit && (hits_reg != '1))
        begin
            hits_next = hits_reg + 1'b1;
        end
        if (fault && (faults_reg != '1))
        begin
            faults_next = faults_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tlb_valid_reg   <= '0;
            slot_reg        <= '0;
            table_valid_reg <= '0;
            free_reg        <= '0;
            total_reg       <= '0;
            hits_reg        <= '0;
            faults_reg      <= '0;
            done_reg        <= 1'b0;
        end
        else
        begin
            tlb_valid_reg   <= tlb_valid_next;
            slot_reg        <= slot_next;
            table_valid_reg <= table_valid_next;
            free_reg        <= free_next;
            total_reg       <= total_next;
            hits_reg        <= hits_next;
            faults_reg      <= faults_next;
            done_reg        <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            va_reg <= virtual_address;
        end
        if (cmd.finish_walk)
        begin
            tlb_page_reg[slot_adv]  <= page;
            tlb_frame_reg[slot_adv] <= walk_frame;
        end
        if (cmd.finish_hit)
        begin
            phys_reg  <= ADDR_WIDTH'({lookup_frame, offset});
            hit_reg   <= 1'b1;
            fault_reg <= 1'b0;
        end
        else if (cmd.finish_walk)
        begin
            phys_reg  <= ADDR_WIDTH'({walk_frame, offset});
            hit_reg   <= 1'b0;
            fault_reg <= fault;
        end
    end

    assign done              = done_reg;
    assign phys_addr         = phys_reg;
    assign tlb_hit           = hit_reg;
    assign page_fault        = fault_reg;
    assign translation_count = total_reg;
    assign hit_count         = hits_reg;
    assign fault_count       = faults_reg;

endmodule

`default_nettype wire
